>>> sv/tmrr_pkg.sv
package tmrr_pkg;

  // fixed field widths
  localparam int unsigned COORD_W = 8;
  localparam int unsigned SIDE_W  = 9;
  localparam int unsigned HOP_W   = 9;
  localparam int unsigned TOTAL_W = 10;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned NDIM    = 3;

  // largest ring side that the coordinates can address
  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(256);

  // topology modes
  localparam logic [1:0] MODE_MESH  = 2'd0;
  localparam logic [1:0] MODE_TORUS = 2'd1;
  localparam logic [1:0] MODE_UNI   = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SELF  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_Z = 3'd4;

  // packed port widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic [SIDE_W-1:0]        side_t;
  typedef logic signed [HOP_W-1:0]  hop_t;
  typedef logic [COORD_W-1:0]       mag_t;
  typedef logic [TOTAL_W-1:0]       total_t;
  typedef logic [ERR_W-1:0]         err_t;

endpackage

>>> sv/torus_mesh_routing_record.sv
// Minimal route offsets for a 1 to 3 dimensional mesh, torus or unidirectional
// torus. Each transaction on the in_ channel carries source and destination
// coordinates; the out_ channel returns the signed hop count per dimension, the
// total hop count and an error code (range error wins over a self-sent packet,
// both give zero offsets). The block is a three-stage pipeline (wrap subtract,
// direction choice, hop sum) whose last register drives the out_ channel; one
// transaction can be accepted every cycle unless stalled; each stage holds its
// item while the stage behind it is full, so out_tready low stalls without loss.
// Configuration registers are written through the cfg_ port, which is always
// ready; write them only while no transaction is in flight.
module torus_mesh_routing_record (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmrr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tmrr_pkg::SIDE_W-1:0]           cfg_data,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // src_x, src_y, src_z, dst_x, dst_y, dst_z (8 bits each)
  input  logic [tmrr_pkg::IN_DATA_W-1:0]        in_tdata,
  // tie_negative
  input  logic                                  in_tuser,
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hops_x, hops_y, hops_z (9 bits signed each), total_hops (10 bits), 3 zero bits
  output logic [tmrr_pkg::OUT_DATA_W-1:0]       out_tdata,
  // error_code
  output logic [tmrr_pkg::ERR_W-1:0]            out_tuser
);

  import tmrr_pkg::*;

  // configuration registers
  logic [1:0] mode_r;
  logic [1:0] dims_r;
  side_t      side_r [NDIM];

  // effective configuration
  side_t      side_eff [NDIM];
  logic [NDIM-1:0] used;
  logic       mesh_mode;

  // stage 1: wrapped and plain differences, error flags
  logic       v1_r;
  hop_t       diff1_r [NDIM];
  side_t      wrap1_r [NDIM];
  logic       tie1_r;
  logic       rerr1_r;
  logic       same1_r;
  hop_t       diff1_nxt [NDIM];
  side_t      wrap1_nxt [NDIM];
  logic       rerr1_nxt;
  logic       same1_nxt;

  // stage 2: chosen offsets and magnitudes
  logic       v2_r;
  hop_t       hop2_r [NDIM];
  mag_t       mag2_r [NDIM];
  err_t       err2_r;
  hop_t       hop2_nxt [NDIM];
  mag_t       mag2_nxt [NDIM];

  // stage 3: output register
  logic       v3_r;
  hop_t       hop3_r [NDIM];
  total_t     total3_r;
  err_t       err3_r;
  total_t     total3_nxt;

  // stage advance
  logic       adv1;
  logic       adv2;
  logic       adv3;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TORUS;
      dims_r    <= 2'd3;
      side_r[0] <= SIDE_W'(8);
      side_r[1] <= SIDE_W'(8);
      side_r[2] <= SIDE_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r    <= cfg_data[1:0];
        REG_DIMS:   dims_r    <= cfg_data[1:0];
        REG_SIDE_X: side_r[0] <= cfg_data;
        REG_SIDE_Y: side_r[1] <= cfg_data;
        REG_SIDE_Z: side_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sides, used dimensions and mode
  always_comb begin
    for (int i = 0; i < NDIM; i++) begin
      side_eff[i] = (side_r[i] > MAX_SIDE) ? MAX_SIDE : side_r[i];
    end
    used[0] = 1'b1;
    used[1] = (dims_r >= 2'd2);
    used[2] = (dims_r == 2'd3);
    mesh_mode = (mode_r != MODE_TORUS) && (mode_r != MODE_UNI);
  end

  // pipeline flow control
  assign adv3      = !v3_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  // stage 1 logic: range check, equality, difference and wrap
  always_comb begin
    coord_t s;
    coord_t d;
    rerr1_nxt = 1'b0;
    same1_nxt = 1'b1;
    for (int i = 0; i < NDIM; i++) begin
      s = in_tdata[i*COORD_W +: COORD_W];
      d = in_tdata[(i+NDIM)*COORD_W +: COORD_W];
      diff1_nxt[i] = hop_t'({1'b0, d}) - hop_t'({1'b0, s});
      wrap1_nxt[i] = diff1_nxt[i][HOP_W-1] ? side_t'(diff1_nxt[i]) + side_eff[i]
                                            : side_t'(diff1_nxt[i]);
      if (used[i]) begin
        if ({1'b0, s} >= side_eff[i] || {1'b0, d} >= side_eff[i]) begin
          rerr1_nxt = 1'b1;
        end
        if (s != d) begin
          same1_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      diff1_r <= diff1_nxt;
      wrap1_r <= wrap1_nxt;
      tie1_r  <= in_tuser;
      rerr1_r <= rerr1_nxt;
      same1_r <= same1_nxt;
    end
  end

  // stage 2 logic: pick the direction per dimension
  always_comb begin
    logic [SIDE_W:0]   twice;
    logic signed [HOP_W:0] neg;
    hop_t h;
    for (int i = 0; i < NDIM; i++) begin
      twice = {wrap1_r[i], 1'b0};
      neg   = $signed({1'b0, wrap1_r[i]}) - $signed({1'b0, side_eff[i]});
      if (mesh_mode) begin
        h = diff1_r[i];
      end else if (mode_r == MODE_UNI) begin
        h = hop_t'(wrap1_r[i]);
      end else if (twice > {1'b0, side_eff[i]} ||
                   (twice == {1'b0, side_eff[i]} && tie1_r)) begin
        h = hop_t'(neg);
      end else begin
        h = hop_t'(wrap1_r[i]);
      end
      if (!used[i]) begin
        h = '0;
      end
      hop2_nxt[i] = h;
      mag2_nxt[i] = h[HOP_W-1] ? mag_t'(-h) : mag_t'(h);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      hop2_r <= hop2_nxt;
      mag2_r <= mag2_nxt;
      err2_r <= rerr1_r ? ERR_RANGE : (same1_r ? ERR_SELF : ERR_NONE);
    end
  end

  // stage 3 logic: total hop count
  assign total3_nxt = total_t'(mag2_r[0]) + total_t'(mag2_r[1]) + total_t'(mag2_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      err3_r <= err2_r;
      if (err2_r != ERR_NONE) begin
        hop3_r[0] <= '0;
        hop3_r[1] <= '0;
        hop3_r[2] <= '0;
        total3_r  <= '0;
      end else begin
        hop3_r   <= hop2_r;
        total3_r <= total3_nxt;
      end
    end
  end

  // result packing
  assign out_tvalid = v3_r;
  assign out_tdata  = {3'b000, total3_r, hop3_r[2], hop3_r[1], hop3_r[0]};
  assign out_tuser  = err3_r;

endmodule
